// ===== src/psma_pkg.sv =====
// ----------------------------------------------------------------------------
// Polyline simplification package
// Shared payload types, sizes, status codes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package psma_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned MaxPoints = 64;
  localparam int unsigned IdxBits   = $clog2(MaxPoints);
  localparam int unsigned CntBits   = 7;
  localparam int unsigned ScoreBits = 56;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PARM = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic signed [CoordBits-1:0] z;
    logic                        last;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic signed [CoordBits-1:0] out_x;
    logic signed [CoordBits-1:0] out_y;
    logic signed [CoordBits-1:0] out_z;
    logic                        out_last;
  } out_word_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_INIT_SEL,
    S_SCORE_RD,
    S_SCORE_WAIT,
    S_SCORE_WR,
    S_SCAN,
    S_FIND_P,
    S_FIND_Q,
    S_RESC_P,
    S_FIND_PP,
    S_RESC_Q,
    S_FIND_QQ,
    S_EMIT_RD,
    S_EMIT,
    S_ERR,
    S_CLEAR
  } state_t;

endpackage

// ===== src/polyline_simplify_min_area_core.sv =====
// ----------------------------------------------------------------------------
// Polyline simplification core
// Least effective area point removal over a stored 3-D polyline.
// ----------------------------------------------------------------------------
// Usage: points enter on the in_valid/in_stall channel, one word per cycle
// while the core is loading; a word with last set closes the polyline.
// From then on in_stall stays high until the run's final output word has
// been taken and the run state has been cleared. The core first scores
// every interior point through one shared scorer (point reads, then the
// scorer, then a score write). Each removal then scans the live scores at
// one entry per cycle, walks to the live neighbors one step per cycle and
// rescores up to two of them. Kept points leave on the out_valid/out_stall
// channel, each read from the point memory before its word is offered, the
// final one marked out_last; an error run gives a single status word
// instead. When the receiver stalls, the output word holds and the core
// waits. Reset clears the control state and the removal marks and sets
// keep_count to 2; point and score memories are not cleared. keep_count is
// written over the APB port at address 0; the user must write it only
// while the core is idle, as the core itself does not enforce this.
// ----------------------------------------------------------------------------
module polyline_simplify_min_area_core import psma_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned PTW = 3 * CoordBits;

  logic [CntBits-1:0] keep_count;
  state_t state, state_next;

  logic [PTW-1:0] pmem [MaxPoints];
  logic [ScoreBits-1:0] smem [MaxPoints];
  logic [MaxPoints-1:0] removed;

  logic [CntBits-1:0] count, remaining, kept, emitted, last_idx;
  logic overflow;
  logic [IdxBits-1:0] idx, cmp_idx, m, p, q, pp, qq, win;
  logic [IdxBits-1:0] ra, rb, rc, wr_idx, init_i;
  logic cmp_vld;
  logic [2:0] rd_sel;
  logic [PTW-1:0] pa, pb, prd;
  logic found;
  logic [ScoreBits-1:0] best, srd;
  logic phase_init, resc_q_pending;
  logic sc_start, sc_done;
  logic [ScoreBits-1:0] sc_score;
  status_t err_code;
  logic in_acc;
  logic scan_hit, scan_end, more, init_more;
  logic to_scan, to_emit;

  assign pready = 1'b1;
  assign prdata = 32'(keep_count);
  always_ff @(posedge clk) begin
    if (rst) keep_count <= CntBits'(2);
    else if (psel && penable && pwrite && pready && !paddr) keep_count <= pwdata[CntBits-1:0];
  end

  assign in_stall = (state != S_LOAD);
  assign in_acc = in_valid && !in_stall;
  assign last_idx = count - CntBits'(1);

  // Memories: one registered read port each, shared by scoring, scan and emit.
  always_ff @(posedge clk) begin
    if (in_acc && count < CntBits'(MaxPoints))
      pmem[count[IdxBits-1:0]] <= {in_data.x, in_data.y, in_data.z};
    if (state == S_SCORE_WR) smem[wr_idx] <= sc_score;
    prd <= pmem[idx];
    srd <= smem[idx];
  end

  // The third point of a triple is taken straight from the read register.
  psma_scorer #(.CB(CoordBits)) u_scorer (
    .clk, .rst, .start(sc_start),
    .ax(pa[PTW-1 -: CoordBits]), .ay(pa[2*CoordBits-1 -: CoordBits]),
    .az(pa[CoordBits-1:0]),
    .bx(pb[PTW-1 -: CoordBits]), .by(pb[2*CoordBits-1 -: CoordBits]),
    .bz(pb[CoordBits-1:0]),
    .cx(prd[PTW-1 -: CoordBits]), .cy(prd[2*CoordBits-1 -: CoordBits]),
    .cz(prd[CoordBits-1:0]),
    .done(sc_done), .score(sc_score)
  );

  assign sc_start = (state == S_SCORE_RD) && (rd_sel == 3'd4);

  // Scan compares trail the score reads: each entry is compared in the cycle after its read.
  assign scan_hit = cmp_vld && !removed[cmp_idx] && (!found || srd < best);
  assign scan_end = cmp_vld && (CntBits'(cmp_idx) + CntBits'(2) == count);
  assign win = scan_hit ? cmp_idx : m;
  assign more = remaining > keep_count;
  assign init_more = CntBits'(init_i) + CntBits'(2) < count;

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: if (in_acc && in_data.last) state_next = S_INIT_SEL;
      S_INIT_SEL: begin
        if (overflow || count < CntBits'(3) || keep_count < CntBits'(2))
          state_next = S_ERR;
        else if (keep_count >= count) state_next = S_EMIT_RD;
        else state_next = S_SCORE_RD;
      end
      S_SCORE_RD: if (rd_sel == 3'd4) state_next = S_SCORE_WAIT;
      S_SCORE_WAIT: if (sc_done) state_next = S_SCORE_WR;
      S_SCORE_WR: begin
        if (phase_init) state_next = init_more ? S_SCORE_RD : S_SCAN;
        else if (resc_q_pending) state_next = S_RESC_Q;
        else state_next = more ? S_SCAN : S_EMIT_RD;
      end
      S_SCAN: if (scan_end) state_next = (found || scan_hit) ? S_FIND_P : S_EMIT_RD;
      S_FIND_P: if (p == '0 || !removed[p]) state_next = S_FIND_Q;
      S_FIND_Q: if (CntBits'(q) >= last_idx || !removed[q]) state_next = S_RESC_P;
      S_RESC_P: state_next = (p != '0) ? S_FIND_PP : S_RESC_Q;
      S_FIND_PP: if (pp == '0 || !removed[pp]) state_next = S_SCORE_RD;
      S_RESC_Q: begin
        if (CntBits'(q) < last_idx) state_next = S_FIND_QQ;
        else state_next = more ? S_SCAN : S_EMIT_RD;
      end
      S_FIND_QQ: if (CntBits'(qq) >= last_idx || !removed[qq]) state_next = S_SCORE_RD;
      S_EMIT_RD: if (!removed[idx]) state_next = S_EMIT;
      S_EMIT: if (!out_stall) state_next = out_data.out_last ? S_CLEAR : S_EMIT_RD;
      S_ERR: if (!out_stall) state_next = S_CLEAR;
      S_CLEAR: state_next = S_LOAD;
      default: state_next = S_LOAD;
    endcase
  end

  assign to_scan = (state != S_SCAN) && (state_next == S_SCAN);
  assign to_emit = (state != S_EMIT_RD) && (state != S_EMIT) && (state_next == S_EMIT_RD);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; overflow <= 1'b0; removed <= '0; rd_sel <= '0;
      phase_init <= 1'b0; resc_q_pending <= 1'b0; found <= 1'b0; cmp_vld <= 1'b0;
    end else if (to_scan) begin
      idx <= IdxBits'(1); cmp_vld <= 1'b0; found <= 1'b0; phase_init <= 1'b0;
    end else if (to_emit) begin
      idx <= '0; emitted <= '0; kept <= remaining;
    end else begin
      case (state)
        S_LOAD: if (in_acc) begin
          if (count < CntBits'(MaxPoints)) count <= count + CntBits'(1);
          else overflow <= 1'b1;
          if (in_data.last)
            remaining <= (count < CntBits'(MaxPoints)) ? count + CntBits'(1) : count;
        end
        S_INIT_SEL: begin
          phase_init <= 1'b1; init_i <= IdxBits'(1);
          ra <= '0; rb <= IdxBits'(1); rc <= IdxBits'(2); wr_idx <= IdxBits'(1);
          err_code <= overflow ? ST_OVERFLOW : ST_BAD_PARM;
        end
        S_SCORE_RD: begin
          rd_sel <= (rd_sel == 3'd4) ? 3'd0 : rd_sel + 3'd1;
          case (rd_sel)
            3'd0: idx <= ra;
            3'd1: idx <= rb;
            3'd2: begin idx <= rc; pa <= prd; end
            3'd3: pb <= prd;
            default: ;
          endcase
        end
        S_SCORE_WR: begin
          if (phase_init) begin
            if (init_more) begin
              init_i <= init_i + IdxBits'(1);
              ra <= init_i; rb <= init_i + IdxBits'(1); rc <= init_i + IdxBits'(2);
              wr_idx <= init_i + IdxBits'(1);
            end
          end else if (resc_q_pending) begin
            resc_q_pending <= 1'b0;
          end
        end
        S_SCAN: begin
          if (scan_hit) begin found <= 1'b1; best <= srd; m <= cmp_idx; end
          if (scan_end) begin
            removed[win] <= 1'b1;
            remaining <= remaining - CntBits'(1);
            p <= win - IdxBits'(1);
            q <= win + IdxBits'(1);
          end else begin
            cmp_idx <= idx;
            cmp_vld <= (CntBits'(idx) + CntBits'(2) <= count);
            if (CntBits'(idx) + CntBits'(2) <= count) idx <= idx + IdxBits'(1);
          end
        end
        S_FIND_P: if (!(p == '0 || !removed[p])) p <= p - IdxBits'(1);
        S_FIND_Q: if (!(CntBits'(q) >= last_idx || !removed[q])) q <= q + IdxBits'(1);
        S_RESC_P: pp <= p - IdxBits'(1);
        S_FIND_PP:
          if (pp == '0 || !removed[pp]) begin
            ra <= pp; rb <= p; rc <= q; wr_idx <= p;
            resc_q_pending <= 1'b1;
          end else pp <= pp - IdxBits'(1);
        S_RESC_Q: qq <= q + IdxBits'(1);
        S_FIND_QQ:
          if (CntBits'(qq) >= last_idx || !removed[qq]) begin
            ra <= p; rb <= q; rc <= qq; wr_idx <= q;
            resc_q_pending <= 1'b0;
          end else qq <= qq + IdxBits'(1);
        S_EMIT_RD: if (removed[idx]) idx <= idx + IdxBits'(1);
        S_EMIT: if (!out_stall) begin
          emitted <= emitted + CntBits'(1);
          idx <= idx + IdxBits'(1);
        end
        S_CLEAR: begin
          count <= '0; overflow <= 1'b0; removed <= '0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = (state == S_EMIT) || (state == S_ERR);
  always_comb begin
    out_data = '0;
    if (state == S_ERR) begin
      out_data.status = err_code;
      out_data.out_last = 1'b1;
    end else begin
      out_data.status = ST_OK;
      out_data.out_x = prd[PTW-1 -: CoordBits];
      out_data.out_y = prd[2*CoordBits-1 -: CoordBits];
      out_data.out_z = prd[CoordBits-1:0];
      out_data.out_last = (emitted + CntBits'(1) == kept);
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("output word while input is open");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> !removed[idx])
    else $error("emitting a removed point");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |=> (count == '0 && removed == '0))
    else $error("run state not cleared");
endmodule

// ===== src/psma_scorer.sv =====
// ----------------------------------------------------------------------------
// Shared triangle scorer
// Computes the squared cross product magnitude from three point coordinates
// in registered steps: differences, products, then the sum of squares.
// ----------------------------------------------------------------------------
module psma_scorer import psma_pkg::*; #(
  parameter int unsigned CB = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [CB-1:0]  ax, ay, az,
  input  logic signed [CB-1:0]  bx, by, bz,
  input  logic signed [CB-1:0]  cx, cy, cz,
  output logic                  done,
  output logic [ScoreBits-1:0]  score
);
  localparam int unsigned DW = CB + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = 2 * PW;

  logic [2:0] phase;
  logic signed [DW-1:0] u0, u1, u2, v0, v1, v2;
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [PW-1:0] k0, k1, k2;
  logic [SW-1:0] q0, q1, q2;
  logic [ScoreBits-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else begin
      case (phase)
        3'd0: if (start) phase <= 3'd1;
        3'd4: phase <= 3'd0;
        default: phase <= phase + 3'd1;
      endcase
    end
  end

  // Each stage is registered: differences, products, cross terms, squares and the sum.
  always_ff @(posedge clk) begin
    if (start && phase == 3'd0) begin
      u0 <= DW'(bx) - DW'(ax);
      u1 <= DW'(by) - DW'(ay);
      u2 <= DW'(bz) - DW'(az);
      v0 <= DW'(cx) - DW'(ax);
      v1 <= DW'(cy) - DW'(ay);
      v2 <= DW'(cz) - DW'(az);
    end
    if (phase == 3'd1) begin
      p0 <= u1 * v2; p1 <= u2 * v1;
      p2 <= u2 * v0; p3 <= u0 * v2;
      p4 <= u0 * v1; p5 <= u1 * v0;
    end
    if (phase == 3'd2) begin
      k0 <= p0 - p1;
      k1 <= p2 - p3;
      k2 <= p4 - p5;
    end
    if (phase == 3'd3) begin
      q0 <= SW'(k0 * k0);
      q1 <= SW'(k1 * k1);
      q2 <= SW'(k2 * k2);
    end
    if (phase == 3'd4) begin
      acc <= ScoreBits'(q0) + ScoreBits'(q1) + ScoreBits'(q2);
    end
  end

  assign score = acc;
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= (phase == 3'd4);
  end
endmodule
